### hdl/video_frame_pacer_top_assert.svh
// Assertion macros for the video frame pacer
`ifndef VIDEO_FRAME_PACER_TOP_ASSERT_SVH
`define VIDEO_FRAME_PACER_TOP_ASSERT_SVH

// same-cycle implication
`define VFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vfp_pkg.sv
// Shared types and constants of the video frame pacer
package vfp_pkg;

  localparam int TIME_W     = 32;
  localparam int ID_W       = 6;
  localparam int RATE_W     = 10;
  localparam int POOL_W     = 7;
  localparam int K_W        = 20;
  localparam int PROD_W     = 52;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [RATE_W-1:0] MS_PER_S = 10'd1000;

  localparam logic [CFG_ADDR_W-1:0] REG_RATE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_POOL  = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_TIME   = 3'd0,
    KIND_DROP   = 3'd1,
    KIND_SHOW   = 3'd2,
    KIND_DELAY  = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  typedef struct packed {
    logic              drop;
    logic [TIME_W-1:0] t;
    logic [ID_W-1:0]   id;
  } frame_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_PUT,
    DP_FLUSH,
    DP_MUL_COUNT,
    DP_DIV_PROD,
    DP_DIV_NEXT,
    DP_SAVE_SLOT,
    DP_SAVE_NEXT,
    DP_ADVANCE,
    DP_POP,
    DP_LOAD_HELD,
    DP_RELEASE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_PUT,
    S_REJECT,
    S_FLUSH,
    S_POOL_DIV,
    S_POOL_WAIT,
    S_DELAY,
    S_MUL,
    S_DIV_SLOT,
    S_WAIT_SLOT,
    S_DIV_NEXT,
    S_WAIT_NEXT,
    S_CHECK,
    S_FETCH,
    S_LOAD,
    S_EVAL,
    S_TIME
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
    kind_t  kind;
    logic   last;
  } vfp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    fifo_full;
    logic    fifo_empty;
    logic    held_valid;
    logic    late;
    logic    drop_now;
    logic    show_now;
    logic    div_busy;
    logic    out_free;
  } vfp_sts_t;

endpackage

### hdl/vfp_div.sv
// Restoring divider, one quotient bit per cycle
module vfp_div
  import vfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic              busy,
  output logic [PROD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] dvd_r, dvd_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;

  always_comb begin
    trial    = {rem_r, dvd_r[PROD_W-1]};
    diff     = trial - {1'b0, dsr_r};
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[PROD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[RATE_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[RATE_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### hdl/vfp_dp.sv
// Datapath: config, frame queue, timing registers, divider and output register
module vfp_dp
  import vfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vfp_cmd_t              cmd,
  output vfp_sts_t              sts,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]            in_opcode,
  input  logic [TIME_W-1:0]     in_now,
  input  frame_t                in_frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kind_t                 out_kind,
  output logic [ID_W-1:0]       out_id,
  output logic [TIME_W-1:0]     out_value,
  output logic                  out_last
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [RATE_W-1:0] rate_r, scale_r;
  logic [POOL_W-1:0] pool_r;
  logic [K_W-1:0]    k_r;

  opcode_t           opcode_r;
  logic [TIME_W-1:0] now_r;
  frame_t            inf_r;

  logic [TIME_W-1:0] count_r, ref_r, slot_r, next_r;
  logic [PROD_W-1:0] prod_r;
  frame_t            held_r, rd_r;
  logic              held_valid_r;

  frame_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0]  fcount_r;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TIME_W-1:0] out_value_r;
  logic              out_last_r;

  logic              div_start, div_busy;
  logic [PROD_W-1:0] div_dvd, div_quo;
  logic [RATE_W-1:0] divisor;
  logic              out_free;
  logic [TIME_W-1:0] elapsed;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign divisor   = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign div_start = (cmd.op == DP_DIV_PROD) || (cmd.op == DP_DIV_NEXT);
  assign div_dvd   = (cmd.op == DP_DIV_NEXT) ? prod_r + PROD_W'(k_r) : prod_r;

  vfp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign out_free = !out_valid_r || out_ready;
  assign elapsed  = now_r - ref_r;

  always_comb begin
    sts.opcode     = opcode_r;
    sts.fifo_full  = (fcount_r == CNT_W'(QUEUE_DEPTH));
    sts.fifo_empty = (fcount_r == '0);
    sts.held_valid = held_valid_r;
    sts.late       = $signed(elapsed) > $signed(slot_r);
    sts.drop_now   = held_r.drop && ($signed(held_r.t) < $signed(slot_r));
    sts.show_now   = $signed(held_r.t) < $signed(next_r);
    sts.div_busy   = div_busy;
    sts.out_free   = out_free;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_W'(60);
      scale_r <= RATE_W'(1);
      pool_r  <= POOL_W'(16);
      k_r     <= K_W'(1000);
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_RATE:  rate_r  <= cfg_wdata;
          REG_SCALE: scale_r <= cfg_wdata;
          REG_POOL:  pool_r  <= cfg_wdata[POOL_W-1:0];
          default:   ;
        endcase
      end
      k_r <= K_W'(scale_r) * K_W'(MS_PER_S);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (cmd.op == DP_PUT) mem[tail_r] <= inf_r;
    if (cmd.op == DP_POP) rd_r <= mem[head_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == DP_LATCH) begin
      now_r <= in_now;
      inf_r <= in_frame;
    end
    if (cmd.op == DP_MUL_COUNT) prod_r <= count_r * k_r;
    if (cmd.op == DP_FLUSH)     prod_r <= PROD_W'(pool_r) * PROD_W'(k_r);
    if (cmd.op == DP_SAVE_NEXT) next_r <= div_quo[TIME_W-1:0];
    if (cmd.op == DP_LOAD_HELD) held_r <= rd_r;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_r     <= OP_NONE;
      count_r      <= '0;
      ref_r        <= '0;
      slot_r       <= '0;
      held_valid_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      fcount_r     <= '0;
    end else begin
      unique case (cmd.op)
        DP_LATCH:     opcode_r <= opcode_t'(in_opcode);
        DP_PUT: begin
          tail_r   <= ptr_inc(tail_r);
          fcount_r <= fcount_r + 1'b1;
        end
        DP_FLUSH: begin
          head_r       <= '0;
          tail_r       <= '0;
          fcount_r     <= '0;
          held_valid_r <= 1'b0;
          count_r      <= '0;
          ref_r        <= now_r;
        end
        DP_SAVE_SLOT: slot_r <= div_quo[TIME_W-1:0];
        DP_ADVANCE:   count_r <= count_r + 1'b1;
        DP_POP: begin
          head_r   <= ptr_inc(head_r);
          fcount_r <= fcount_r - 1'b1;
        end
        DP_LOAD_HELD: held_valid_r <= 1'b1;
        DP_RELEASE:   held_valid_r <= 1'b0;
        default:      ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit && out_free) begin
      out_kind_r <= cmd.kind;
      out_last_r <= cmd.last;
      case (cmd.kind)
        KIND_DROP, KIND_SHOW: begin
          out_id_r    <= held_r.id;
          out_value_r <= held_r.t;
        end
        KIND_REJECT: begin
          out_id_r    <= inf_r.id;
          out_value_r <= inf_r.t;
        end
        KIND_DELAY: begin
          out_id_r    <= '0;
          out_value_r <= div_quo[TIME_W-1:0];
        end
        default: begin
          out_id_r    <= '0;
          out_value_r <= slot_r;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_id    = out_id_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

### hdl/vfp_ctrl.sv
// Controller state machine of the video frame pacer
module vfp_ctrl
  import vfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vfp_sts_t sts,
  output vfp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (sts.opcode)
          OP_PUT:   state_nxt = sts.fifo_full ? S_REJECT : S_PUT;
          OP_TICK:  state_nxt = S_MUL;
          OP_FLUSH: state_nxt = S_FLUSH;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_PUT:       state_nxt = S_IDLE;
      S_REJECT:    if (sts.out_free) state_nxt = S_IDLE;
      S_FLUSH:     state_nxt = S_POOL_DIV;
      S_POOL_DIV:  state_nxt = S_POOL_WAIT;
      S_POOL_WAIT: if (!sts.div_busy) state_nxt = S_DELAY;
      S_DELAY:     if (sts.out_free) state_nxt = S_IDLE;
      S_MUL:       state_nxt = S_DIV_SLOT;
      S_DIV_SLOT:  state_nxt = S_WAIT_SLOT;
      S_WAIT_SLOT: if (!sts.div_busy) state_nxt = S_DIV_NEXT;
      S_DIV_NEXT:  state_nxt = S_WAIT_NEXT;
      S_WAIT_NEXT: if (!sts.div_busy) state_nxt = S_CHECK;
      S_CHECK: begin
        if (!sts.late)          state_nxt = S_TIME;
        else if (sts.held_valid) state_nxt = S_EVAL;
        else                    state_nxt = S_FETCH;
      end
      S_FETCH:     state_nxt = sts.fifo_empty ? S_TIME : S_LOAD;
      S_LOAD:      state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.drop_now) begin
          if (sts.out_free) state_nxt = S_FETCH;
        end else if (sts.show_now) begin
          if (sts.out_free) state_nxt = S_TIME;
        end else begin
          state_nxt = S_TIME;
        end
      end
      S_TIME:      if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = DP_NONE;
    cmd.emit = 1'b0;
    cmd.kind = KIND_TIME;
    cmd.last = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LATCH;
      end
      S_PUT:      cmd.op = DP_PUT;
      S_REJECT: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_REJECT;
        cmd.last = 1'b1;
      end
      S_FLUSH:    cmd.op = DP_FLUSH;
      S_POOL_DIV: cmd.op = DP_DIV_PROD;
      S_DELAY: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_DELAY;
        cmd.last = 1'b1;
      end
      S_MUL:      cmd.op = DP_MUL_COUNT;
      S_DIV_SLOT: cmd.op = DP_DIV_PROD;
      S_WAIT_SLOT: if (!sts.div_busy) cmd.op = DP_SAVE_SLOT;
      S_DIV_NEXT: cmd.op = DP_DIV_NEXT;
      S_WAIT_NEXT: if (!sts.div_busy) cmd.op = DP_SAVE_NEXT;
      S_CHECK:    if (sts.late) cmd.op = DP_ADVANCE;
      S_FETCH:    if (!sts.fifo_empty) cmd.op = DP_POP;
      S_LOAD:     cmd.op = DP_LOAD_HELD;
      S_EVAL: begin
        if (sts.drop_now || sts.show_now) begin
          cmd.emit = 1'b1;
          cmd.kind = sts.drop_now ? KIND_DROP : KIND_SHOW;
          if (sts.out_free) cmd.op = DP_RELEASE;
        end
      end
      S_TIME: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_TIME;
        cmd.last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hdl/video_frame_pacer_top.sv
// Video frame pacer: paces queued frames to a fixed display rate.
// Input channel (in_*): tuser carries the opcode (put, tick, flush), tdata the
// current time and the frame descriptor. Result channel (out_*): tuser is the
// result kind, tdata the frame id and value, tlast marks the last result of
// an input item. cfg_* writes frame_rate, frame_scale and pool_frames.
// One item is worked at a time; in_tready is high only while idle.
// A tick runs two serial divisions; a late tick then also walks the frame
// already held and the frames popped from the queue, which may run empty.
// A flush runs one division. Division is a restoring divider producing one
// quotient bit per cycle. Results pass through one output register; a
// stalled receiver holds the controller until the register frees, so no
// result is lost. Synchronous reset clears the queue, counters and config
// to defaults.
module video_frame_pacer_top
  import vfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [71:0]           in_tdata,  // now_time, frame_id, frame_time, droppable
  input  logic [1:0]            in_tuser,  // opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata, // frame_id_res, value
  output logic [2:0]            out_tuser, // kind
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  vfp_cmd_t          cmd;
  vfp_sts_t          sts;
  frame_t            in_frame;
  kind_t             out_kind;
  logic [ID_W-1:0]   out_id;
  logic [TIME_W-1:0] out_value;

  assign in_frame.id   = in_tdata[37:32];
  assign in_frame.t    = in_tdata[69:38];
  assign in_frame.drop = in_tdata[70];

  vfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vfp_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_opcode (in_tuser),
    .in_now    (in_tdata[31:0]),
    .in_frame  (in_frame),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_id    (out_id),
    .out_value (out_value),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_kind;
  assign out_tdata = {2'b00, out_value, out_id};

`include "video_frame_pacer_top_assert.svh"

  `VFP_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "second item taken while busy")
  `VFP_ASSERT_NOW(a_fifo_state, clk, rst_n, sts.fifo_full, !sts.fifo_empty, "queue both full and empty")
  `VFP_ASSERT_NOW(a_kind_range, clk, rst_n, out_tvalid, out_tuser <= KIND_REJECT, "result kind out of range")

endmodule

### tb/sv/video_frame_pacer_top_test.sv
// Self-checking testbench of the video frame pacer: directed and random stream stimulus, predicted results.
module video_frame_pacer_top_test;
  import vfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LIMIT = 2000000;
  localparam int SETTLE = 200;

  typedef struct {
    opcode_t     op;
    logic [31:0] now;
    logic [5:0]  id;
    logic [31:0] ft;
    logic        drop;
  } pacer_req_t;

  typedef struct {
    kind_t       kind;
    logic [5:0]  id;
    logic [31:0] value;
    logic        last;
  } pacer_res_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid, out_tready = 0, out_tlast;
  logic [39:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  video_frame_pacer_top dut (.*);

  initial forever #1 clk = ~clk;

  pacer_req_t pending_reqs[$];
  pacer_res_t expected_res[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0, recv_idle = 0;

  // predictor state
  logic [9:0]  p_rate, p_scale;
  logic [6:0]  p_pool;
  logic [31:0] p_count, p_ref, p_slot;
  logic        p_held_valid;
  frame_t      p_held;
  frame_t      p_fifo[DEPTH];
  int          p_head, p_tail, p_fill;

  function automatic logic [31:0] slot_ms(logic [63:0] cnt);
    logic [63:0] r;
    r = (p_rate == 0) ? 64'd1 : 64'(p_rate);
    return 32'((cnt * 64'd1000 * 64'(p_scale)) / r);
  endfunction

  function automatic void push_res(kind_t k, logic [5:0] id, logic [31:0] v);
    pacer_res_t r;
    r.kind = k; r.id = id; r.value = v; r.last = 0;
    expected_res.push_back(r);
  endfunction

  function automatic logic pop_queue();
    if (p_fill == 0) return 0;
    p_held = p_fifo[p_head];
    p_head = (p_head + 1) % DEPTH;
    p_fill--;
    return 1;
  endfunction

  function automatic void predict_pacer(pacer_req_t q);
    int n_prior;
    logic [31:0] nxt;
    n_prior = expected_res.size();
    case (q.op)
      OP_PUT: begin
        if (p_fill >= DEPTH) push_res(KIND_REJECT, q.id, q.ft);
        else begin
          p_fifo[p_tail] = '{drop: q.drop, t: q.ft, id: q.id};
          p_tail = (p_tail + 1) % DEPTH;
          p_fill++;
        end
      end
      OP_TICK: begin
        p_slot = slot_ms(64'(p_count));
        nxt = slot_ms(64'(p_count) + 64'd1);
        if ($signed(q.now - p_ref) > $signed(p_slot)) begin
          p_count++;
          if (!p_held_valid) p_held_valid = pop_queue();
          while (p_held_valid) begin
            if (p_held.drop && $signed(p_held.t) < $signed(p_slot)) begin
              push_res(KIND_DROP, p_held.id, p_held.t);
              p_held_valid = pop_queue();
            end else if ($signed(p_held.t) < $signed(nxt)) begin
              push_res(KIND_SHOW, p_held.id, p_held.t);
              p_held_valid = 0;
              break;
            end else break;
          end
        end
        push_res(KIND_TIME, '0, p_slot);
      end
      OP_FLUSH: begin
        p_head = 0; p_tail = 0; p_fill = 0;
        p_held_valid = 0;
        p_count = 0;
        p_ref = q.now;
        push_res(KIND_DELAY, '0, slot_ms(64'(p_pool)));
      end
      default: ;
    endcase
    if (expected_res.size() > n_prior) expected_res[$].last = 1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_pacer(pending_reqs[0]);
        void'(pending_reqs.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_tvalid <= 1;
          in_tuser <= pending_reqs[0].op;
          in_tdata <= {1'b0, pending_reqs[0].drop, pending_reqs[0].ft,
                       pending_reqs[0].id, pending_reqs[0].now};
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_res.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected transfer kind=%0d data=%h", out_tuser, out_tdata);
          mismatches <= mismatches + 1;
        end else begin
          if (out_tuser !== expected_res[0].kind || out_tdata[5:0] !== expected_res[0].id ||
              out_tdata[37:6] !== expected_res[0].value || out_tlast !== expected_res[0].last)
          begin
            if (mismatches < 10)
              $display({"mismatch: exp kind=%0d id=%0d val=%h last=%b, ",
                        "got kind=%0d id=%0d val=%h last=%b"},
                       expected_res[0].kind, expected_res[0].id, expected_res[0].value,
                       expected_res[0].last, out_tuser, out_tdata[5:0], out_tdata[37:6],
                       out_tlast);
            mismatches <= mismatches + 1;
          end
          void'(expected_res.pop_front());
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1; cfg_addr <= a; cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 0;
    case (a)
      REG_RATE: p_rate = d;
      REG_SCALE: p_scale = d;
      REG_POOL: p_pool = d[6:0];
      default: ;
    endcase
  endtask

  task automatic drain_pacer();
    while (pending_reqs.size() > 0 || expected_res.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void add_req(opcode_t op, logic [31:0] now, logic [5:0] id,
                                  logic [31:0] ft, logic drop);
    pacer_req_t q;
    q.op = op; q.now = now; q.id = id; q.ft = ft; q.drop = drop;
    pending_reqs.push_back(q);
  endfunction

  // random run: flush, then puts and ticks near the display slots, bursts of puts, random opcodes and further flushes
  task automatic random_phase(int n);
    logic [31:0] base, rel;
    int period, k;
    period = (1000 * p_scale) / ((p_rate == 0) ? 1 : p_rate);
    if (period < 1) period = 1;
    if (period > 5000) period = 5000;
    base = $urandom;
    rel = 0;
    add_req(OP_FLUSH, base, 6'($urandom), $urandom, 1'($urandom));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        add_req(OP_PUT, $urandom, 6'($urandom),
                rel + $urandom_range(4 * period) - 2 * period, 1'($urandom));
      end else if (k < 85) begin
        rel += $urandom_range(2 * period);
        add_req(OP_TICK, base + rel, 6'($urandom), $urandom, 1'($urandom));
      end else if (k < 90) begin
        repeat (18) add_req(OP_PUT, $urandom, 6'($urandom), rel + $urandom_range(period),
                            1'($urandom));
      end else if (k < 96) begin
        add_req(opcode_t'($urandom_range(3)), $urandom, 6'($urandom), $urandom,
                1'($urandom));
      end else begin
        base = base + rel; rel = 0;
        add_req(OP_FLUSH, base, 6'($urandom), $urandom, 1'($urandom));
      end
    end
  endtask

  initial begin
    p_rate = 60; p_scale = 1; p_pool = 16;
    p_count = 0; p_ref = 0; p_slot = 0; p_held_valid = 0;
    p_head = 0; p_tail = 0; p_fill = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_idle = 20; recv_idle = 70;

    // directed
    add_req(OP_TICK, 32'h0, 6'd0, 32'h0, 1'b0);
    add_req(OP_PUT, 32'hFFFF_FFFF, 6'd63, 32'h8000_0000, 1'b1);
    add_req(OP_PUT, 32'h0, 6'd0, 32'h7FFF_FFFF, 1'b0);
    add_req(OP_PUT, 32'h0, 6'd5, 32'd10, 1'b0);
    add_req(OP_TICK, 32'd100, 6'd0, 32'h0, 1'b0);
    add_req(OP_TICK, 32'hFFFF_FFFF, 6'd0, 32'h0, 1'b0);
    add_req(OP_NONE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1);
    add_req(OP_FLUSH, 32'hFFFF_FF00, 6'd0, 32'h0, 1'b0);
    for (int i = 0; i < 17; i++)
      add_req(OP_PUT, 32'h0, 6'(i), 32'(i), 1'b1);
    add_req(OP_TICK, 32'h0000_0200, 6'd0, 32'h0, 1'b0);
    drain_pacer();

    write_reg(REG_RATE, 10'd1); write_reg(REG_SCALE, 10'd1000); write_reg(REG_POOL, 10'd64);
    random_phase(16);
    drain_pacer();

    send_idle = 70; recv_idle = 20;
    write_reg(REG_RATE, 10'd1000); write_reg(REG_SCALE, 10'd1); write_reg(REG_POOL, 10'd0);
    random_phase(16);
    drain_pacer();
    write_reg(REG_RATE, 10'd0); write_reg(REG_SCALE, 10'd1023); write_reg(REG_POOL, 10'd127);
    random_phase(14);
    drain_pacer();

    send_idle = 0; recv_idle = 0;
    write_reg(REG_RATE, 10'd24); write_reg(REG_SCALE, 10'd1); write_reg(REG_POOL, 10'd5);
    random_phase(16);
    drain_pacer();
    write_reg(REG_RATE, 10'd304); write_reg(REG_SCALE, 10'd1001);
    write_reg(REG_POOL, 10'd33);
    random_phase(16);
    drain_pacer();

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

### filelist.f
+incdir+hdl
hdl/vfp_pkg.sv
hdl/vfp_div.sv
hdl/vfp_dp.sv
hdl/vfp_ctrl.sv
hdl/video_frame_pacer_top.sv
tb/sv/video_frame_pacer_top_test.sv
